// ===== hdl/ace_pkg.sv =====
// Package for the ANSI text console engine.
// Holds the parser mode and action encodings, byte codes, register indexes
// and the result structure. No dependencies.
package ace_pkg;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_ESC    = 2'd1,
    MODE_CSI    = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_CLEAR = 2'd2
  } action_e;

  localparam logic CFG_SCREEN_COLS = 1'b0;
  localparam logic CFG_SCREEN_ROWS = 1'b1;

  localparam logic [7:0] COLS_RESET = 8'd80;
  localparam logic [7:0] ROWS_RESET = 8'd25;
  localparam logic [2:0] FG_RESET   = 3'd7;
  localparam logic [2:0] BG_RESET   = 3'd0;

  localparam logic [7:0] CH_BS        = 8'h08;
  localparam logic [7:0] CH_LF        = 8'h0a;
  localparam logic [7:0] CH_CR        = 8'h0d;
  localparam logic [7:0] CH_ESC       = 8'h1b;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_TILDE     = 8'h7e;
  localparam logic [7:0] CH_DEL       = 8'h7f;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_NINE      = 8'h39;
  localparam logic [7:0] CH_SAVE      = 8'h37;
  localparam logic [7:0] CH_RESTORE   = 8'h38;
  localparam logic [7:0] CH_SEMICOLON = 8'h3b;
  localparam logic [7:0] CH_LBRACKET  = 8'h5b;
  localparam logic [7:0] CH_SGR       = 8'h6d;
  localparam logic [7:0] CH_LEFT      = 8'h44;
  localparam logic [7:0] CH_RIGHT     = 8'h43;
  localparam logic [7:0] CH_POS_H     = 8'h48;
  localparam logic [7:0] CH_POS_F     = 8'h66;
  localparam logic [7:0] CH_ERASE     = 8'h4a;

  localparam logic [7:0] SGR_FG_LO    = 8'd30;
  localparam logic [7:0] SGR_FG_HI    = 8'd37;
  localparam logic [7:0] SGR_BG_LO    = 8'd40;
  localparam logic [7:0] SGR_BG_HI    = 8'd47;
  localparam logic [7:0] SGR_FG_DEF   = 8'd39;
  localparam logic [7:0] SGR_BG_DEF   = 8'd49;
  localparam logic [7:0] ERASE_ALL    = 8'd2;
  localparam logic [7:0] PARAM_MAX    = 8'd255;

  typedef struct packed {
    action_e    action;
    logic [7:0] cell_row;
    logic [7:0] cell_col;
    logic [7:0] cell_char;
    logic [2:0] fg;
    logic [2:0] bg;
    logic       scroll;
    logic [7:0] pos_row;
    logic [7:0] pos_col;
  } result_t;

endpackage

// ===== hdl/ace_in_stage.sv =====
// Input register of the ANSI text console engine.
// Holds one accepted byte until the engine consumes it. No dependencies.
module ace_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] byte_in_i,
  input  logic       take_i,
  output logic       valid_o,
  output logic [7:0] byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;

  assign in_ready_o = !valid_q || take_i;
  assign valid_d    = (in_valid_i && in_ready_o) || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= byte_in_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

// ===== hdl/ace_engine.sv =====
// Terminal state and per-byte update logic of the ANSI text console engine.
// Holds cursor, colours, parser mode, CSI parameters and screen size.
// Depends on ace_pkg.
module ace_engine import ace_pkg::*; #(
  parameter int PARAM_SLOTS = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_index_i,
  input  logic [7:0] cfg_data_i,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  output result_t    result_o
);

  localparam int IDX_W  = (PARAM_SLOTS > 1) ? $clog2(PARAM_SLOTS) : 1;
  localparam int PIDX_W = $clog2(PARAM_SLOTS + 1);
  localparam logic [PIDX_W-1:0] SLOTS = PIDX_W'(PARAM_SLOTS);

  logic [7:0]        cols_q, rows_q;
  logic [7:0]        row_q, row_d, col_q, col_d;
  logic [7:0]        srow_q, srow_d, scol_q, scol_d;
  logic [2:0]        fg_q, fg_d, bg_q, bg_d;
  mode_e             mode_q, mode_d;
  logic [7:0]        par_q [PARAM_SLOTS];
  logic [7:0]        par_d [PARAM_SLOTS];
  logic [PIDX_W-1:0] pidx_q, pidx_d;

  logic [7:0] rmax, cmax, cr, cc;
  logic       is_digit, slot_free;

  assign rmax = (rows_q == 8'd0) ? 8'd0 : rows_q - 8'd1;
  assign cmax = (cols_q == 8'd0) ? 8'd0 : cols_q - 8'd1;
  assign cr   = (row_q > rmax) ? rmax : row_q;
  assign cc   = (col_q > cmax) ? cmax : col_q;

  assign is_digit  = (byte_i >= CH_ZERO) && (byte_i <= CH_NINE);
  assign slot_free = pidx_q < SLOTS;

  always_comb begin
    unique case (mode_q)
      MODE_NORMAL: begin
        mode_d = (byte_i == CH_ESC) ? MODE_ESC : MODE_NORMAL;
      end
      MODE_ESC: begin
        mode_d = (byte_i == CH_LBRACKET) ? MODE_CSI : MODE_NORMAL;
      end
      MODE_CSI: begin
        if (is_digit || (byte_i == CH_SEMICOLON && slot_free)) begin
          mode_d = MODE_CSI;
        end else begin
          mode_d = MODE_NORMAL;
        end
      end
      default: begin
        mode_d = MODE_NORMAL;
      end
    endcase
  end

  always_comb begin
    logic [7:0]        p0, p1, n, tmp;
    logic [8:0]        sum9;
    logic [11:0]       acc;
    logic              wrap;
    logic [PIDX_W-1:0] cnt;

    result_o            = '0;
    result_o.action     = ACT_NONE;
    row_d  = cr;
    col_d  = cc;
    srow_d = srow_q;
    scol_d = scol_q;
    fg_d   = fg_q;
    bg_d   = bg_q;
    par_d  = par_q;
    pidx_d = pidx_q;
    p0     = par_q[0];
    p1     = (pidx_q != '0) ? par_q[1] : 8'd0;
    n      = (p0 == 8'd0) ? 8'd1 : p0;
    sum9   = {1'b0, cc} + {1'b0, n};
    acc    = '0;
    wrap   = 1'b0;
    tmp    = '0;
    cnt    = slot_free ? pidx_q + PIDX_W'(1) : SLOTS;

    unique case (mode_q)
      MODE_NORMAL: begin
        if (byte_i == CH_DEL || byte_i == CH_BS) begin
          if (cc != 8'd0) begin
            col_d = cc - 8'd1;
          end else if (cr != 8'd0) begin
            row_d = cr - 8'd1;
            col_d = cmax;
          end
          if (byte_i == CH_DEL && (cc != 8'd0 || cr != 8'd0)) begin
            result_o.action    = ACT_WRITE;
            result_o.cell_row  = row_d;
            result_o.cell_col  = col_d;
            result_o.cell_char = CH_SPACE;
          end
        end else if (byte_i == CH_CR) begin
          col_d = 8'd0;
        end else if (byte_i == CH_LF) begin
          col_d = 8'd0;
          wrap  = 1'b1;
        end else if (byte_i >= CH_SPACE && byte_i <= CH_TILDE) begin
          result_o.action    = ACT_WRITE;
          result_o.cell_row  = cr;
          result_o.cell_col  = cc;
          result_o.cell_char = byte_i;
          if (cc >= cmax) begin
            col_d = 8'd0;
            wrap  = 1'b1;
          end else begin
            col_d = cc + 8'd1;
          end
        end
        if (wrap) begin
          if (cr >= rmax) begin
            row_d           = rmax;
            result_o.scroll = 1'b1;
          end else begin
            row_d = cr + 8'd1;
          end
        end
      end
      MODE_ESC: begin
        if (byte_i == CH_SAVE) begin
          srow_d = cr;
          scol_d = cc;
        end else if (byte_i == CH_RESTORE) begin
          row_d = (srow_q > rmax) ? rmax : srow_q;
          col_d = (scol_q > cmax) ? cmax : scol_q;
        end else if (byte_i == CH_LBRACKET) begin
          for (int i = 0; i < PARAM_SLOTS; i++) begin
            par_d[i] = 8'd0;
          end
          pidx_d = '0;
        end
      end
      MODE_CSI: begin
        if (is_digit) begin
          if (slot_free) begin
            acc = 12'(par_q[pidx_q[IDX_W-1:0]]) * 12'd10 + 12'(byte_i - CH_ZERO);
            par_d[pidx_q[IDX_W-1:0]] = (acc > 12'(PARAM_MAX)) ? PARAM_MAX : acc[7:0];
          end
        end else if (byte_i == CH_SEMICOLON && slot_free) begin
          pidx_d = pidx_q + PIDX_W'(1);
        end else begin
          pidx_d = cnt;
          if (byte_i == CH_SGR) begin
            for (int i = 0; i < PARAM_SLOTS; i++) begin
              if (PIDX_W'(i) < cnt) begin
                if (par_q[i] >= SGR_FG_LO && par_q[i] <= SGR_FG_HI) begin
                  tmp  = par_q[i] - SGR_FG_LO;
                  fg_d = tmp[2:0];
                end else if (par_q[i] >= SGR_BG_LO && par_q[i] <= SGR_BG_HI) begin
                  tmp  = par_q[i] - SGR_BG_LO;
                  bg_d = tmp[2:0];
                end else if (par_q[i] == SGR_FG_DEF) begin
                  fg_d = FG_RESET;
                end else if (par_q[i] == SGR_BG_DEF) begin
                  bg_d = BG_RESET;
                end
              end
            end
          end else if (byte_i == CH_LEFT) begin
            col_d = (n >= cc) ? 8'd0 : cc - n;
          end else if (byte_i == CH_RIGHT) begin
            col_d = (sum9 > {1'b0, cmax}) ? cmax : sum9[7:0];
          end else if (byte_i == CH_POS_H || byte_i == CH_POS_F) begin
            tmp   = (p0 == 8'd0) ? 8'd0 : p0 - 8'd1;
            row_d = (tmp > rmax) ? rmax : tmp;
            tmp   = (p1 == 8'd0) ? 8'd0 : p1 - 8'd1;
            col_d = (tmp > cmax) ? cmax : tmp;
          end else if (byte_i == CH_ERASE) begin
            if (p0 == ERASE_ALL) begin
              result_o.action = ACT_CLEAR;
              row_d           = 8'd0;
              col_d           = 8'd0;
            end
          end
        end
      end
      default: begin
      end
    endcase

    result_o.fg      = fg_d;
    result_o.bg      = bg_d;
    result_o.pos_row = row_d;
    result_o.pos_col = col_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= COLS_RESET;
      rows_q <= ROWS_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SCREEN_COLS: cols_q <= cfg_data_i;
        CFG_SCREEN_ROWS: rows_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= 8'd0;
      col_q  <= 8'd0;
      srow_q <= 8'd0;
      scol_q <= 8'd0;
      fg_q   <= FG_RESET;
      bg_q   <= BG_RESET;
      mode_q <= MODE_NORMAL;
      pidx_q <= '0;
      for (int i = 0; i < PARAM_SLOTS; i++) begin
        par_q[i] <= 8'd0;
      end
    end else if (step_i) begin
      row_q  <= row_d;
      col_q  <= col_d;
      srow_q <= srow_d;
      scol_q <= scol_d;
      fg_q   <= fg_d;
      bg_q   <= bg_d;
      mode_q <= mode_d;
      pidx_q <= pidx_d;
      par_q  <= par_d;
    end
  end

endmodule

// ===== hdl/ace_out_stage.sv =====
// Result register of the ANSI text console engine.
// Holds one result beat until the receiver takes it. Depends on ace_pkg.
module ace_out_stage import ace_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t result_i,
  output logic    room_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t result_o
);

  logic    valid_q, valid_d;
  result_t result_q;

  assign room_o  = !valid_q || out_ready_i;
  assign valid_d = load_i || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

// ===== hdl/ansi_text_console_engine_core.sv =====
// Top level of the ANSI text console engine: input register, terminal
// update logic and result register. Depends on ace_pkg, ace_in_stage,
// ace_engine and ace_out_stage.
//
// Bytes arrive on the in_valid_i/in_ready_o channel, one beat per byte.
// Every byte yields exactly one result beat on out_valid_o/out_ready_i:
// the action (none, write one cell, clear the screen), the cell address
// and character, the current colours, a scroll flag and the new cursor.
// A byte waits in the input register while its update is worked out and
// stored into the result register, which then presents its result beat.
// One byte per cycle is taken while the receiver keeps taking results.
// When the receiver stalls, the result register holds its beat; one more
// byte may wait in the input register, after which in_ready_o drops.
// Reset empties both registers, homes the cursor and the saved cursor,
// sets white on black, the normal parser state and an 80 by 25 screen.
// The screen size is written through cfg_we_i/cfg_index_i/cfg_data_i, index 0 for
// columns and 1 for rows, by the user while no bytes are in flight; the block does not enforce this.
module ansi_text_console_engine_core import ace_pkg::*; #(
  parameter int PARAM_SLOTS = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_index_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] byte_in_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] action_o,
  output logic [7:0] cell_row_o,
  output logic [7:0] cell_col_o,
  output logic [7:0] cell_char_o,
  output logic [2:0] fg_out_o,
  output logic [2:0] bg_out_o,
  output logic       scroll_up_o,
  output logic [7:0] cursor_row_out_o,
  output logic [7:0] cursor_col_out_o
);

  logic       pend_valid, room, step;
  logic [7:0] pend_byte;
  result_t    next_result, result;

  assign step = pend_valid && room;

  ace_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .byte_in_i  (byte_in_i),
    .take_i     (step),
    .valid_o    (pend_valid),
    .byte_o     (pend_byte)
  );

  ace_engine #(
    .PARAM_SLOTS (PARAM_SLOTS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .step_i      (step),
    .byte_i      (pend_byte),
    .result_o    (next_result)
  );

  ace_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step),
    .result_i    (next_result),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (result)
  );

  assign action_o         = result.action;
  assign cell_row_o       = result.cell_row;
  assign cell_col_o       = result.cell_col;
  assign cell_char_o      = result.cell_char;
  assign fg_out_o         = result.fg;
  assign bg_out_o         = result.bg;
  assign scroll_up_o      = result.scroll;
  assign cursor_row_out_o = result.pos_row;
  assign cursor_col_out_o = result.pos_col;

endmodule
